[rtl/core/enu_pkg.sv]
// ----------------------------------------------------------------------------
// enu_pkg
// Shared types and constants of the geodetic to local ENU converter.
// ----------------------------------------------------------------------------
package enu_pkg;

  localparam int CORDIC_STAGES = 30;

  // Register stages in every rounding multiplier, from operands to product.
  localparam int MUL_LAT = 5;

  // Register stages of one ellipsoid to Earth-centred conversion.
  localparam int ECEF_LAT = 75 + CORDIC_STAGES;

  localparam logic [63:0] TURN_DIV  = 64'd3515625;
  localparam logic [63:0] TURN_HALF = 64'd1757812;
  // Reciprocal of the turn divisor, scaled by 2^62 (angle << 22 over 2^40).
  localparam logic [63:0] TURN_RCP  = (64'd1 << 62) / TURN_DIV;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [63:0] E2_Q32      = 64'sd28752143;
  localparam logic signed [63:0] OME2_Q32    = 64'sd4266215153;
  localparam logic signed [63:0] A_MM        = 64'sd6378137000;
  localparam logic signed [63:0] ONE_Q60     = 64'sd1 <<< 60;
  localparam logic signed [63:0] THREE_Q60   = 64'sd3 <<< 60;
  localparam logic signed [63:0] ENU_LIMIT   = 64'sd13000000000;
  localparam logic signed [63:0] INT64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam logic [31:0] ATAN_TURN [40] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef enum logic [1:0] {
    CFG_REF_LAT = 2'd0,
    CFG_REF_LON = 2'd1,
    CFG_REF_ALT = 2'd2
  } cfg_idx_t;

  // Sine and cosine of latitude and longitude, Q2.30.
  typedef struct packed {
    logic signed [31:0] sl;
    logic signed [31:0] cl;
    logic signed [31:0] sp;
    logic signed [31:0] cp;
  } trig_t;

  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

endpackage

[rtl/core/geodetic_to_local_enu.sv]
// ----------------------------------------------------------------------------
// geodetic_to_local_enu
// WGS84 fix to east, north and up millimetres around a reference point.
// ----------------------------------------------------------------------------
// The converter is a pipeline that accepts one beat per clock while in_tready
// is high, and returns each result after the input registers, the ellipsoid
// to Earth-centred conversion and the difference, rotation and rounding
// stages. The depth is set by the CORDIC rotation stages and by the chain of
// rounding multipliers that compute the prime-vertical radius. The whole
// pipeline advances whenever the output register is empty or being taken, so
// a full pipeline keeps moving at one beat per cycle under a steady out_tready.
// The reference point is converted by a second pipeline running in step with
// the first; write the reference registers only while no beat is in flight.
module geodetic_to_local_enu
  import enu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // latitude[30:0], longitude[62:31], altitude[89:63]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // east[34:0], north[69:35], up[104:70]
  output logic         out_tuser,  // no_fix
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int LAT = 14 + ECEF_LAT;

  logic en;
  logic vld_r   [1:LAT];
  logic nofix_r [1:LAT];

  logic signed [30:0] ref_lat_r;
  logic signed [31:0] ref_lon_r;
  logic signed [26:0] ref_alt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
      ref_alt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REF_LAT: ref_lat_r <= cfg_data[30:0];
        CFG_REF_LON: ref_lon_r <= cfg_data;
        CFG_REF_ALT: ref_alt_r <= cfg_data[26:0];
        default: ;
      endcase
    end
  end

  assign en        = !vld_r[LAT] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int k = 2; k <= LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  logic signed [30:0] lat_r;
  logic signed [31:0] lon_r;
  logic signed [26:0] alt_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lat_r      <= in_tdata[30:0];
      lon_r      <= in_tdata[62:31];
      alt_r      <= in_tdata[89:63];
      nofix_r[1] <= (in_tdata[89:0] == 90'd0);
      for (int k = 2; k <= LAT; k++) nofix_r[k] <= nofix_r[k-1];
    end
  end

  logic signed [63:0] fx, fy, fz, rx, ry, rz;
  trig_t              ftrig, rtrig;

  enu_ecef u_fix (
    .clk(clk), .en(en), .lat(lat_r), .lon(lon_r), .alt(alt_r),
    .ex(fx), .ey(fy), .ez(fz), .trig(ftrig)
  );

  enu_ecef u_ref (
    .clk(clk), .en(en), .lat(ref_lat_r), .lon(ref_lon_r), .alt(ref_alt_r),
    .ex(rx), .ey(ry), .ez(rz), .trig(rtrig)
  );

  logic signed [63:0] dx_r, dy_r, dz_r;
  trig_t              rt_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= fx - rx;
      dy_r <= fy - ry;
      dz_r <= fz - rz;
      rt_r <= rtrig;
    end
  end

  // First rotation step: products of the differences and of the trig pairs.
  logic signed [63:0] e1, e2, nz, uz, cpsl, slsp, clcp, clsp;

  enu_mul u_e1 (.clk(clk), .en(en), .a(64'sd0 - sx32(rt_r.sp)), .b(dx_r), .sh(6'd30),
                .p(e1));
  enu_mul u_e2 (.clk(clk), .en(en), .a(sx32(rt_r.cp)), .b(dy_r), .sh(6'd30), .p(e2));
  enu_mul u_nz (.clk(clk), .en(en), .a(sx32(rt_r.cl)), .b(dz_r), .sh(6'd30), .p(nz));
  enu_mul u_uz (.clk(clk), .en(en), .a(sx32(rt_r.sl)), .b(dz_r), .sh(6'd30), .p(uz));
  enu_mul u_cpsl (.clk(clk), .en(en), .a(sx32(rt_r.cp)), .b(sx32(rt_r.sl)), .sh(6'd30),
                  .p(cpsl));
  enu_mul u_slsp (.clk(clk), .en(en), .a(sx32(rt_r.sl)), .b(sx32(rt_r.sp)), .sh(6'd30),
                  .p(slsp));
  enu_mul u_clcp (.clk(clk), .en(en), .a(sx32(rt_r.cl)), .b(sx32(rt_r.cp)), .sh(6'd30),
                  .p(clcp));
  enu_mul u_clsp (.clk(clk), .en(en), .a(sx32(rt_r.cl)), .b(sx32(rt_r.sp)), .sh(6'd30),
                  .p(clsp));

  logic signed [63:0] dxd_r [1:MUL_LAT];
  logic signed [63:0] dyd_r [1:MUL_LAT];
  logic signed [63:0] ed_r  [1:MUL_LAT];
  logic signed [63:0] nzd_r [1:MUL_LAT];
  logic signed [63:0] uzd_r [1:MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dxd_r[1] <= dx_r;
      dyd_r[1] <= dy_r;
      ed_r[1]  <= e1 + e2;
      nzd_r[1] <= nz;
      uzd_r[1] <= uz;
      for (int k = 2; k <= MUL_LAT; k++) begin
        dxd_r[k] <= dxd_r[k-1];
        dyd_r[k] <= dyd_r[k-1];
        ed_r[k]  <= ed_r[k-1];
        nzd_r[k] <= nzd_r[k-1];
        uzd_r[k] <= uzd_r[k-1];
      end
    end
  end

  logic signed [63:0] n1, n2, u1, u2;

  enu_mul u_n1 (.clk(clk), .en(en), .a(64'sd0 - cpsl), .b(dxd_r[MUL_LAT]), .sh(6'd30),
                .p(n1));
  enu_mul u_n2 (.clk(clk), .en(en), .a(slsp), .b(dyd_r[MUL_LAT]), .sh(6'd30), .p(n2));
  enu_mul u_u1 (.clk(clk), .en(en), .a(clcp), .b(dxd_r[MUL_LAT]), .sh(6'd30), .p(u1));
  enu_mul u_u2 (.clk(clk), .en(en), .a(clsp), .b(dyd_r[MUL_LAT]), .sh(6'd30), .p(u2));

  logic signed [63:0] east_s_r, north_s_r, up_s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      east_s_r  <= ed_r[MUL_LAT];
      north_s_r <= n1 - n2 + nzd_r[MUL_LAT];
      up_s_r    <= u1 + u2 + uzd_r[MUL_LAT];
    end
  end

  // Round to the nearest millimetre (ties upward) and clamp to the range.
  function automatic logic [34:0] to_mm(input logic signed [63:0] v);
    logic signed [63:0] mm;
    mm = (v + 64'sd128) >>> 8;
    if (mm > ENU_LIMIT) begin
      mm = ENU_LIMIT;
    end else if (mm < -ENU_LIMIT) begin
      mm = -ENU_LIMIT;
    end
    to_mm = mm[34:0];
  endfunction

  logic [34:0] east_r, north_r, up_r;

  always_ff @(posedge clk) begin
    if (en) begin
      east_r  <= nofix_r[LAT-1] ? 35'd0 : to_mm(east_s_r);
      north_r <= nofix_r[LAT-1] ? 35'd0 : to_mm(north_s_r);
      up_r    <= nofix_r[LAT-1] ? 35'd0 : to_mm(up_s_r);
    end
  end

  assign out_tvalid = vld_r[LAT];
  assign out_tdata  = {7'd0, up_r, north_r, east_r};
  assign out_tuser  = nofix_r[LAT];

endmodule

[rtl/core/enu_mul.sv]
// ----------------------------------------------------------------------------
// enu_mul
// Pipelined 64 x 64 signed multiply, rounded half away from zero after a
// right shift, saturating in magnitude. Built from four 32 x 32 products.
// ----------------------------------------------------------------------------
module enu_mul
  import enu_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [5:0]         sh,
  output logic signed [63:0] p
);

  logic signed [63:0] a_r, b_r;
  logic [5:0]         sh0_r, sh1_r, sh2_r, sh3_r;
  logic [63:0]        ua_r, ub_r;
  logic               neg1_r, neg2_r, neg3_r;
  logic [63:0]        p00_r, p01_r, p10_r, p11_r;
  logic [127:0]       sum_r;
  logic [127:0]       rnd_nxt, shr_nxt;
  logic [63:0]        mag_nxt;
  logic signed [63:0] p_r;

  always_comb begin
    rnd_nxt = sum_r + (128'd1 << (sh3_r - 6'd1));
    shr_nxt = rnd_nxt >> sh3_r;
    mag_nxt = (shr_nxt > {64'd0, INT64_MAX}) ? INT64_MAX : shr_nxt[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a;
      b_r    <= b;
      sh0_r  <= sh;
      ua_r   <= a_r[63] ? 64'd0 - a_r : a_r;
      ub_r   <= b_r[63] ? 64'd0 - b_r : b_r;
      neg1_r <= a_r[63] ^ b_r[63];
      sh1_r  <= sh0_r;
      p00_r  <= ua_r[31:0] * ub_r[31:0];
      p01_r  <= ua_r[31:0] * ub_r[63:32];
      p10_r  <= ua_r[63:32] * ub_r[31:0];
      p11_r  <= ua_r[63:32] * ub_r[63:32];
      neg2_r <= neg1_r;
      sh2_r  <= sh1_r;
      sum_r  <= {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
                + {p11_r, 64'd0};
      neg3_r <= neg2_r;
      sh3_r  <= sh2_r;
      p_r    <= neg3_r ? 64'sd0 - $signed(mag_nxt) : $signed(mag_nxt);
    end
  end

  assign p = p_r;

endmodule

[rtl/core/enu_ecef.sv]
// ----------------------------------------------------------------------------
// enu_ecef
// Geodetic point to Earth-centred coordinates (mm, 8 fraction bits), with the
// sine and cosine of its latitude and longitude. Fully pipelined.
// ----------------------------------------------------------------------------
module enu_ecef
  import enu_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [30:0] lat,
  input  logic signed [31:0] lon,
  input  logic signed [26:0] alt,
  output logic signed [63:0] ex,
  output logic signed [63:0] ey,
  output logic signed [63:0] ez,
  output trig_t              trig
);

  localparam int S   = CORDIC_STAGES;
  localparam int T1  = 9 + S;
  localparam int TB  = T1 + 1 + MUL_LAT;
  localparam int TN  = TB + 9 * MUL_LAT;
  localparam int TNB = TN + MUL_LAT;
  localparam int TX  = TNB + MUL_LAT;
  localparam int TE  = TX + MUL_LAT;

  logic signed [26:0] h_d [1:TX];
  logic [31:0]        ang_in [2];
  logic signed [31:0] cs_r [2];
  logic signed [31:0] sn_r [2];
  trig_t              tr_t1;
  trig_t              tr_d [T1+1:TE];

  assign ang_in[0] = {lat[30], lat};
  assign ang_in[1] = lon;

  always_ff @(posedge clk) begin
    if (en) begin
      h_d[1] <= alt;
      for (int k = 2; k <= TX; k++) h_d[k] <= h_d[k-1];
    end
  end

  // Angle to binary turn, then sine and cosine.
  for (genvar j = 0; j < 2; j++) begin : g_ang
    logic [31:0]        m_nxt;
    logic [31:0]        m_d [1:6];
    logic               neg_d [1:6];
    logic signed [63:0] q0;
    logic [32:0]        q0_r;
    logic [54:0]        prod_r;
    logic signed [56:0] rem_nxt;
    logic [32:0]        q_nxt;
    logic [31:0]        ang_r;
    logic [31:0]        fold_nxt;
    logic signed [33:0] x_s [0:S];
    logic signed [33:0] y_s [0:S];
    logic signed [33:0] z_s [0:S];
    logic               f_s [0:S];

    assign m_nxt = ang_in[j][31] ? 32'd0 - ang_in[j] : ang_in[j];

    enu_mul u_rcp (
      .clk(clk), .en(en), .a({32'd0, m_nxt}), .b(TURN_RCP), .sh(6'd40), .p(q0)
    );

    always_comb begin
      rem_nxt = $signed({3'd0, m_d[6], 22'd0}) + $signed(57'(TURN_HALF))
                - $signed({2'd0, prod_r});
      if (rem_nxt < 0) begin
        q_nxt = q0_r - 33'd1;
      end else if (rem_nxt >= $signed(57'(TURN_DIV))) begin
        q_nxt = q0_r + 33'd1;
      end else begin
        q_nxt = q0_r;
      end
      fold_nxt = ang_r + 32'h4000_0000;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_d[1]   <= m_nxt;
        neg_d[1] <= ang_in[j][31];
        for (int k = 2; k <= 6; k++) begin
          m_d[k]   <= m_d[k-1];
          neg_d[k] <= neg_d[k-1];
        end
        q0_r   <= q0[32:0];
        prod_r <= {22'd0, q0[32:0]} * {33'd0, TURN_DIV[21:0]};
        ang_r  <= neg_d[6] ? 32'd0 - q_nxt[31:0] : q_nxt[31:0];
        // Second and third quadrant angles turn by half a turn, results negate.
        f_s[0] <= fold_nxt[31];
        z_s[0] <= fold_nxt[31] ? 34'($signed(ang_r + 32'h8000_0000))
                               : 34'($signed(ang_r));
        x_s[0] <= CORDIC_GAIN;
        y_s[0] <= 34'sd0;
      end
    end

    for (genvar i = 0; i < S; i++) begin : g_rot
      localparam logic signed [33:0] ATN = {2'b00, ATAN_TURN[i]};
      always_ff @(posedge clk) begin
        if (en) begin
          f_s[i+1] <= f_s[i];
          if (!z_s[i][33]) begin
            x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
            y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
            z_s[i+1] <= z_s[i] - ATN;
          end else begin
            x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
            y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
            z_s[i+1] <= z_s[i] + ATN;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs_r[j] <= f_s[S] ? 32'(-x_s[S]) : 32'(x_s[S]);
        sn_r[j] <= f_s[S] ? 32'(-y_s[S]) : 32'(y_s[S]);
      end
    end
  end

  assign tr_t1 = '{sl: sn_r[0], cl: cs_r[0], sp: sn_r[1], cp: cs_r[1]};

  always_ff @(posedge clk) begin
    if (en) begin
      tr_d[T1+1] <= tr_t1;
      for (int k = T1 + 2; k <= TE; k++) tr_d[k] <= tr_d[k-1];
    end
  end

  // Prime-vertical radius: u = e^2 sin^2, y = 1/sqrt(1 - u) by Newton steps.
  logic signed [63:0] s2_r;
  logic signed [63:0] u;
  logic signed [63:0] w_nxt;
  logic signed [63:0] w_d [1:35];
  logic signed [63:0] y_it [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= tr_t1.sl * tr_t1.sl;
    end
  end

  enu_mul u_esq (.clk(clk), .en(en), .a(E2_Q32), .b(s2_r), .sh(6'd32), .p(u));

  assign w_nxt   = ONE_Q60 - u;
  assign y_it[0] = ONE_Q60 + (u >>> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      w_d[1] <= w_nxt;
      for (int k = 2; k <= 35; k++) w_d[k] <= w_d[k-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_newton
    logic signed [63:0] yy, wyy;
    logic signed [63:0] yd [1:10];

    always_ff @(posedge clk) begin
      if (en) begin
        yd[1] <= y_it[k];
        for (int d = 2; d <= 10; d++) yd[d] <= yd[d-1];
      end
    end

    enu_mul u_yy (.clk(clk), .en(en), .a(y_it[k]), .b(y_it[k]), .sh(6'd60), .p(yy));
    enu_mul u_wyy (.clk(clk), .en(en), .a(w_d[5 + 15 * k]), .b(yy), .sh(6'd60),
                   .p(wyy));
    enu_mul u_upd (.clk(clk), .en(en), .a(yd[10]), .b(THREE_Q60 - wyy),
                   .sh(6'd61), .p(y_it[k+1]));
  end

  logic signed [63:0] n_rad, nb, pp;
  logic signed [63:0] hq_nb, hq_x;

  assign hq_nb = {{29{h_d[TNB][26]}}, h_d[TNB], 8'd0};
  assign hq_x  = {{29{h_d[TX][26]}}, h_d[TX], 8'd0};

  enu_mul u_n (.clk(clk), .en(en), .a(A_MM), .b(y_it[3]), .sh(6'd52), .p(n_rad));
  enu_mul u_nb (.clk(clk), .en(en), .a(n_rad), .b(OME2_Q32), .sh(6'd32), .p(nb));
  enu_mul u_rc (.clk(clk), .en(en), .a(n_rad + hq_nb), .b(sx32(tr_d[TNB].cl)),
                .sh(6'd30), .p(pp));
  enu_mul u_x (.clk(clk), .en(en), .a(pp), .b(sx32(tr_d[TX].cp)), .sh(6'd30), .p(ex));
  enu_mul u_y (.clk(clk), .en(en), .a(pp), .b(sx32(tr_d[TX].sp)), .sh(6'd30), .p(ey));
  enu_mul u_z (.clk(clk), .en(en), .a(nb + hq_x), .b(sx32(tr_d[TX].sl)), .sh(6'd30),
               .p(ez));

  assign trig = tr_d[TE];

endmodule
